@@ rtl/core/orb_pkg.sv @@
// ----------------------------------------------------------------------------
// orb_pkg
// Types, constants and an index helper shared by the overwriting ring buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package orb_pkg;

   // buffer geometry
   localparam int DEPTH   = 64;
   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int WORD_W  = 32;

   // transaction field widths
   localparam int OP_W    = 2;
   localparam int RIDX_W  = 6;
   localparam int ENTRY_W = 7;

   localparam logic [WORD_W-1:0] QNAN_BITS = 32'h7FC0_0000;

   // opcodes
   localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH  = 2'd1;
   localparam logic [OP_W-1:0] OP_POP   = 2'd2;
   localparam logic [OP_W-1:0] OP_READ  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [WORD_W-1:0] push_value;
      logic [RIDX_W-1:0] read_index;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]  read_value;
      logic [WORD_W-1:0]  first_value;
      logic [WORD_W-1:0]  last_value;
      logic [ENTRY_W-1:0] entry_count;
      logic               is_empty;
      logic               overwrote_oldest;
   } rsp_type;

   // commands from the controller to the word store
   typedef struct packed {
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      logic [WORD_W-1:0] wr_data;
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
   } mem_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_RESP
   } state_type;

   // sum is always below twice the depth, so one compare and subtract wraps it
   function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] sum);
      logic [SUM_W-1:0] adj;
      begin
         adj = sum;
         if (sum >= SUM_W'(DEPTH)) begin
            adj = sum - SUM_W'(DEPTH);
         end
         return adj[IDX_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/orb_ram.sv @@
// ----------------------------------------------------------------------------
// orb_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/orb_ctrl.sv @@
// ----------------------------------------------------------------------------
// orb_ctrl
// Pointer, occupancy and sequencing logic of the ring buffer. Keeps the
// oldest and newest words cached so each transaction needs at most one
// read of the word store.
// ----------------------------------------------------------------------------
`default_nettype none

module orb_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  orb_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output orb_pkg::rsp_type          rsp_data,
   output orb_pkg::mem_cmd_type      mem_cmd,
   input  logic [orb_pkg::WORD_W-1:0] mem_rd_data
);

   import orb_pkg::*;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] first_ff, first_in;
   logic [WORD_W-1:0] last_ff, last_in;
   logic [WORD_W-1:0] rd_ff, rd_in;
   logic              ovw_ff, ovw_in;
   logic              to_rd_ff, to_rd_in;
   logic              hit_ff, hit_in;
   logic [DEPTH-1:0]  valid_ff, valid_in;

   logic              accept;
   logic              need_fetch;
   logic              is_full;
   logic              is_empty_now;
   logic [IDX_W-1:0]  head_next;
   logic [IDX_W-1:0]  tail_slot;
   logic [IDX_W-1:0]  read_slot;
   logic [IDX_W-1:0]  ridx_wrapped;
   logic [WORD_W-1:0] fetch_word;

   assign accept       = req_valid && !req_stall;
   assign is_full      = (count_ff == CNT_W'(DEPTH));
   assign is_empty_now = (count_ff == '0);
   assign head_next    = wrap_idx(SUM_W'(head_ff) + SUM_W'(1));
   assign tail_slot    = wrap_idx(SUM_W'(head_ff) + SUM_W'(count_ff));
   assign ridx_wrapped = IDX_W'(req_data.read_index % DEPTH);
   assign read_slot    = wrap_idx(SUM_W'(head_ff) + SUM_W'(ridx_wrapped));
   // entries never written since reset read as zero
   assign fetch_word   = hit_ff ? mem_rd_data : '0;

   // datapath and store commands
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      first_in   = first_ff;
      last_in    = last_ff;
      rd_in      = rd_ff;
      ovw_in     = ovw_ff;
      to_rd_in   = to_rd_ff;
      hit_in     = hit_ff;
      valid_in   = valid_ff;
      need_fetch = 1'b0;
      mem_cmd    = '0;

      if (accept) begin
         rd_in  = '0;
         ovw_in = 1'b0;
         case (req_data.opcode)
            OP_PUSH: begin
               mem_cmd.wr_en       = 1'b1;
               mem_cmd.wr_addr     = tail_slot;
               mem_cmd.wr_data     = req_data.push_value;
               valid_in[tail_slot] = 1'b1;
               last_in             = req_data.push_value;
               if (is_full) begin
                  ovw_in  = 1'b1;
                  head_in = head_next;
                  if (DEPTH == 1) begin
                     first_in = req_data.push_value;
                  end else begin
                     // new oldest entry has to come from the store
                     need_fetch      = 1'b1;
                     mem_cmd.rd_en   = 1'b1;
                     mem_cmd.rd_addr = head_next;
                     to_rd_in        = 1'b0;
                  end
               end else begin
                  count_in = count_ff + CNT_W'(1);
                  if (is_empty_now) begin
                     first_in = req_data.push_value;
                  end
               end
            end
            OP_POP: begin
               if (is_empty_now) begin
                  rd_in = QNAN_BITS;
               end else begin
                  rd_in = first_ff;
                  if (count_ff == CNT_W'(1)) begin
                     head_in  = '0;
                     count_in = '0;
                  end else begin
                     head_in         = head_next;
                     count_in        = count_ff - CNT_W'(1);
                     need_fetch      = 1'b1;
                     mem_cmd.rd_en   = 1'b1;
                     mem_cmd.rd_addr = head_next;
                     to_rd_in        = 1'b0;
                  end
               end
            end
            OP_READ: begin
               need_fetch      = 1'b1;
               mem_cmd.rd_en   = 1'b1;
               mem_cmd.rd_addr = read_slot;
               to_rd_in        = 1'b1;
            end
            default: begin
            end
         endcase
         if (mem_cmd.rd_en) begin
            hit_in = valid_ff[mem_cmd.rd_addr];
         end
      end

      if (state_ff == ST_FETCH) begin
         if (to_rd_ff) begin
            rd_in = fetch_word;
         end else begin
            first_in = fetch_word;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = need_fetch ? ST_FETCH : ST_RESP;
            end
         end
         ST_FETCH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // handshake and result
   always_comb begin
      req_stall                 = (state_ff != ST_IDLE);
      rsp_valid                 = (state_ff == ST_RESP);
      rsp_data.read_value       = rd_ff;
      rsp_data.first_value      = (count_ff == '0) ? QNAN_BITS : first_ff;
      rsp_data.last_value       = (count_ff == '0) ? QNAN_BITS : last_ff;
      rsp_data.entry_count      = ENTRY_W'(count_ff);
      rsp_data.is_empty         = (count_ff == '0);
      rsp_data.overwrote_oldest = ovw_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_ff <= first_in;
      last_ff  <= last_in;
      rd_ff    <= rd_in;
      ovw_ff   <= ovw_in;
      to_rd_ff <= to_rd_in;
      hit_ff   <= hit_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy exceeds depth");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0))
      else $error("head not at zero while empty");

   a_fetch_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> $past(accept))
      else $error("store fetch without an accepted transaction");

   a_state_frozen_in_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP) |=> ($stable(head_ff) && $stable(count_ff)))
      else $error("pointers moved while a result is pending");

endmodule

`default_nettype wire

@@ rtl/core/overwriting_ring_buffer_top.sv @@
// Sequencing: query, push into a non-full buffer and pop of the only entry or of an
//   empty buffer give their result in the cycle after acceptance; read at offset,
//   push into a full buffer and pop that leaves entries pass through ST_FETCH for
//   their one store read, then ST_RESP. A new transaction waits for the last result
//   to leave ST_RESP; the single store read port and one-at-a-time sequencer set this.
// Reset: synchronous; pointers and per-entry valid bits clear together, no sweep.
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_top
// Ring buffer of 32-bit words that overwrites its oldest entry when full.
// ----------------------------------------------------------------------------
`default_nettype none

module overwriting_ring_buffer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  orb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output orb_pkg::rsp_type rsp_data
);

   import orb_pkg::*;

   mem_cmd_type       mem_cmd;
   logic [WORD_W-1:0] mem_rd_data;

   orb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .mem_cmd     (mem_cmd),
      .mem_rd_data (mem_rd_data)
   );

   orb_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_word_store (
      .clock   (clock),
      .wr_en   (mem_cmd.wr_en),
      .wr_addr (mem_cmd.wr_addr),
      .wr_data (mem_cmd.wr_data),
      .rd_en   (mem_cmd.rd_en),
      .rd_addr (mem_cmd.rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

`default_nettype wire
